FILE: src/bb3x3_pkg.sv
// shared constants, types and tap decode for the 3x3 box blur
package bb3x3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	// register port
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	// item kinds
	localparam int KIND_W = 1;
	localparam logic [KIND_W-1:0] KIND_PIXEL = 1'b0;
	localparam logic [KIND_W-1:0] KIND_FLUSH = 1'b1;

	localparam int CHAN_W = 8;
	localparam int NUM_CHAN = 3;
	localparam int PIX_W = NUM_CHAN * CHAN_W;

	// line history: two rows plus two pixels
	localparam int HIST_DEPTH = 2 * MAX_WIDTH + 2;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int SUM_AW     = $clog2(3 * HIST_DEPTH);

	localparam int COUNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int COL_W   = $clog2(MAX_WIDTH);

	// neighbourhood walk
	localparam int NUM_TAPS = 9;
	localparam int STEP_W   = $clog2(NUM_TAPS);
	localparam logic [STEP_W-1:0] LAST_TAP = STEP_W'(NUM_TAPS - 1);

	localparam int SUM_W = $clog2(NUM_TAPS * 255 + 1);
	localparam int CNT_W = $clog2(NUM_TAPS + 1);
	localparam int REM_W = $clog2(2 * NUM_TAPS * 255 + NUM_TAPS + 1);
	localparam int QBIT_W = $clog2(CHAN_W);

	// row / column offset codes
	localparam logic [1:0] OFS_NEG  = 2'd0;
	localparam logic [1:0] OFS_ZERO = 2'd1;
	localparam logic [1:0] OFS_POS  = 2'd2;

	typedef struct packed {
		logic              capture;
		logic              clear;
		logic              rd;
		logic [STEP_W-1:0] step;
		logic              pixel;
		logic              wr;
		logic              div_start;
		logic              div_step;
		logic [QBIT_W-1:0] div_bit;
		logic              load_out;
	} cmd_t;

	typedef struct packed {
		logic history_primed;
		logic frame_full;
		logic emit_ok;
		logic out_free;
	} status_t;

	function automatic logic [1:0] tap_row(input logic [STEP_W-1:0] step);
		logic [1:0] r;
		unique case (step)
			4'd0, 4'd1, 4'd2: r = OFS_NEG;
			4'd3, 4'd4, 4'd5: r = OFS_ZERO;
			4'd6, 4'd7, 4'd8: r = OFS_POS;
			default:          r = OFS_ZERO;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] tap_col(input logic [STEP_W-1:0] step);
		logic [1:0] c;
		unique case (step)
			4'd0, 4'd3, 4'd6: c = OFS_NEG;
			4'd1, 4'd4, 4'd7: c = OFS_ZERO;
			4'd2, 4'd5, 4'd8: c = OFS_POS;
			default:          c = OFS_ZERO;
		endcase
		return c;
	endfunction

endpackage

FILE: src/bb3x3_ifs.sv
// valid/ready channel interfaces for pixels in and blurred pixels out
interface bb3x3_pix_if;
	logic                           valid;
	logic                           ready;
	logic [bb3x3_pkg::KIND_W-1:0]   kind;
	logic [bb3x3_pkg::CHAN_W-1:0]   red_in;
	logic [bb3x3_pkg::CHAN_W-1:0]   green_in;
	logic [bb3x3_pkg::CHAN_W-1:0]   blue_in;

	modport source(output valid, kind, red_in, green_in, blue_in, input ready);
	modport sink(input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface bb3x3_res_if;
	logic                           valid;
	logic                           ready;
	logic [bb3x3_pkg::CHAN_W-1:0]   red_out;
	logic [bb3x3_pkg::CHAN_W-1:0]   green_out;
	logic [bb3x3_pkg::CHAN_W-1:0]   blue_out;
	logic                           last_of_frame;

	modport source(output valid, red_out, green_out, blue_out, last_of_frame, input ready);
	modport sink(input valid, red_out, green_out, blue_out, last_of_frame, output ready);
endinterface

FILE: src/bb3x3_dp.sv
// datapath: frame registers, counters, line history, tap sums, divider, output register
module bb3x3_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bb3x3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bb3x3_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [bb3x3_pkg::CHAN_W-1:0]        red_in,
	input  logic [bb3x3_pkg::CHAN_W-1:0]        green_in,
	input  logic [bb3x3_pkg::CHAN_W-1:0]        blue_in,
	input  bb3x3_pkg::cmd_t                     cmd,
	output bb3x3_pkg::status_t                  status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bb3x3_pkg::CHAN_W-1:0]        red_out,
	output logic [bb3x3_pkg::CHAN_W-1:0]        green_out,
	output logic [bb3x3_pkg::CHAN_W-1:0]        blue_out,
	output logic                                last_of_frame
);

	localparam int WIDTH_W  = bb3x3_pkg::WIDTH_W;
	localparam int HEIGHT_W = bb3x3_pkg::HEIGHT_W;
	localparam int COUNT_W  = bb3x3_pkg::COUNT_W;
	localparam int HIST_AW  = bb3x3_pkg::HIST_AW;
	localparam int SUM_AW   = bb3x3_pkg::SUM_AW;
	localparam int ROW_W    = bb3x3_pkg::ROW_W;
	localparam int COL_W    = bb3x3_pkg::COL_W;
	localparam int CHAN_W   = bb3x3_pkg::CHAN_W;
	localparam int PIX_W    = bb3x3_pkg::PIX_W;
	localparam int NUM_CHAN = bb3x3_pkg::NUM_CHAN;
	localparam int SUM_W    = bb3x3_pkg::SUM_W;
	localparam int CNT_W    = bb3x3_pkg::CNT_W;
	localparam int REM_W    = bb3x3_pkg::REM_W;
	localparam int HIST_DEPTH = bb3x3_pkg::HIST_DEPTH;

	logic [WIDTH_W-1:0]          width_q;
	logic [HEIGHT_W-1:0]         height_q;
	logic [WIDTH_W-1:0]          w_eff;
	logic [HEIGHT_W-1:0]         h_eff;
	logic [WIDTH_W+HEIGHT_W-1:0] area;
	logic [COUNT_W-1:0]          total_q;
	logic [COUNT_W-1:0]          w_plus1;

	logic [COUNT_W-1:0]          taken_q;
	logic [HIST_AW-1:0]          wp_q;
	logic [HIST_AW-1:0]          ep_q;
	logic [ROW_W-1:0]            erow_q;
	logic [COL_W-1:0]            ecol_q;
	logic                        is_last;

	logic [PIX_W-1:0]            cur_q;
	logic [PIX_W-1:0]            hist_mem [HIST_DEPTH];
	logic [PIX_W-1:0]            rd_q;
	logic [HIST_AW-1:0]          rd_addr;
	logic [1:0]                  row_c;
	logic [1:0]                  col_c;
	logic                        row_ok;
	logic                        col_ok;
	logic                        acc_en_s1;
	logic                        cur_sel_s1;
	logic [PIX_W-1:0]            tap;

	logic [SUM_W-1:0]            sum_q [NUM_CHAN];
	logic [CNT_W-1:0]            cnt_q;
	logic [REM_W-1:0]            rem_q [NUM_CHAN];
	logic [CHAN_W-1:0]           quo_q [NUM_CHAN];
	logic [REM_W-1:0]            dsh;

	logic                        out_valid_q;
	logic [CHAN_W-1:0]           red_q;
	logic [CHAN_W-1:0]           green_q;
	logic [CHAN_W-1:0]           blue_q;
	logic                        last_q;

	// clamp the frame size into the supported range
	always_comb begin
		if (width_q == '0)
			w_eff = WIDTH_W'(1);
		else if (width_q > WIDTH_W'(bb3x3_pkg::MAX_WIDTH))
			w_eff = WIDTH_W'(bb3x3_pkg::MAX_WIDTH);
		else
			w_eff = width_q;
		if (height_q == '0)
			h_eff = HEIGHT_W'(1);
		else if (height_q > HEIGHT_W'(bb3x3_pkg::MAX_HEIGHT))
			h_eff = HEIGHT_W'(bb3x3_pkg::MAX_HEIGHT);
		else
			h_eff = height_q;
	end

	assign area    = w_eff * h_eff;
	assign w_plus1 = COUNT_W'(w_eff) + COUNT_W'(1);
	assign is_last = (HEIGHT_W'(erow_q) + HEIGHT_W'(1) == h_eff) &&
	                 (WIDTH_W'(ecol_q) + WIDTH_W'(1) == w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(bb3x3_pkg::WIDTH_RESET);
			height_q <= HEIGHT_W'(bb3x3_pkg::HEIGHT_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				bb3x3_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				bb3x3_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// registered frame size, taken from the clamped width times height
	always_ff @(posedge clk) begin
		total_q <= area[COUNT_W-1:0];
	end

	assign status.history_primed = taken_q >= w_plus1;
	assign status.frame_full     = taken_q >= total_q;
	assign status.emit_ok        = HEIGHT_W'(erow_q) < h_eff;
	assign status.out_free       = !out_valid_q || out_ready;

	// frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
			wp_q    <= '0;
			ep_q    <= '0;
			erow_q  <= '0;
			ecol_q  <= '0;
		end else if (cfg_we) begin
			taken_q <= '0;
			wp_q    <= '0;
			ep_q    <= '0;
			erow_q  <= '0;
			ecol_q  <= '0;
		end else begin
			if (cmd.wr) begin
				taken_q <= taken_q + COUNT_W'(1);
				wp_q    <= (wp_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wp_q + HIST_AW'(1);
			end
			if (cmd.load_out) begin
				if (is_last) begin
					taken_q <= '0;
					wp_q    <= '0;
					ep_q    <= '0;
					erow_q  <= '0;
					ecol_q  <= '0;
				end else begin
					ep_q <= (ep_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : ep_q + HIST_AW'(1);
					if (WIDTH_W'(ecol_q) + WIDTH_W'(1) == w_eff) begin
						ecol_q <= '0;
						erow_q <= erow_q + ROW_W'(1);
					end else begin
						ecol_q <= ecol_q + COL_W'(1);
					end
				end
			end
		end
	end

	// tap address and bounds for the current neighbourhood step
	always_comb begin
		logic [SUM_AW-1:0] a;
		row_c = bb3x3_pkg::tap_row(cmd.step);
		col_c = bb3x3_pkg::tap_col(cmd.step);
		a = SUM_AW'(ep_q) + SUM_AW'(HIST_DEPTH);
		if (row_c == bb3x3_pkg::OFS_POS)
			a = a + SUM_AW'(w_eff);
		else if (row_c == bb3x3_pkg::OFS_NEG)
			a = a - SUM_AW'(w_eff);
		if (col_c == bb3x3_pkg::OFS_POS)
			a = a + SUM_AW'(1);
		else if (col_c == bb3x3_pkg::OFS_NEG)
			a = a - SUM_AW'(1);
		if (a >= SUM_AW'(2 * HIST_DEPTH))
			a = a - SUM_AW'(2 * HIST_DEPTH);
		else if (a >= SUM_AW'(HIST_DEPTH))
			a = a - SUM_AW'(HIST_DEPTH);
		rd_addr = a[HIST_AW-1:0];

		unique case (row_c)
			bb3x3_pkg::OFS_NEG: row_ok = erow_q != '0;
			bb3x3_pkg::OFS_POS: row_ok = HEIGHT_W'(erow_q) + HEIGHT_W'(1) < h_eff;
			default:            row_ok = 1'b1;
		endcase
		unique case (col_c)
			bb3x3_pkg::OFS_NEG: col_ok = ecol_q != '0;
			bb3x3_pkg::OFS_POS: col_ok = WIDTH_W'(ecol_q) + WIDTH_W'(1) < w_eff;
			default:            col_ok = 1'b1;
		endcase
	end

	// line history, read before the new pixel is written
	always_ff @(posedge clk) begin
		if (cmd.wr)
			hist_mem[wp_q] <= cur_q;
		if (cmd.rd)
			rd_q <= hist_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			cur_q <= {red_in, green_in, blue_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1  <= 1'b0;
			cur_sel_s1 <= 1'b0;
		end else begin
			acc_en_s1  <= cmd.rd && row_ok && col_ok;
			// lower-right tap of a pixel transaction is the pixel just taken
			cur_sel_s1 <= cmd.pixel && (row_c == bb3x3_pkg::OFS_POS) &&
			              (col_c == bb3x3_pkg::OFS_POS);
		end
	end

	assign tap = cur_sel_s1 ? cur_q : rd_q;

	// divisor 2*count shifted to the current quotient bit
	assign dsh = REM_W'({cnt_q, 1'b0}) << cmd.div_bit;

	// per-channel sums and restoring division of (2*sum + count) by 2*count
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			cnt_q <= '0;
		end else if (acc_en_s1) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
		for (int c = 0; c < NUM_CHAN; c++) begin
			if (cmd.clear)
				sum_q[c] <= '0;
			else if (acc_en_s1)
				sum_q[c] <= sum_q[c] + SUM_W'(tap[(NUM_CHAN-1-c)*CHAN_W +: CHAN_W]);
			if (cmd.div_start) begin
				rem_q[c] <= REM_W'({sum_q[c], 1'b0}) + REM_W'(cnt_q);
				quo_q[c] <= '0;
			end else if (cmd.div_step && rem_q[c] >= dsh) begin
				rem_q[c]              <= rem_q[c] - dsh;
				quo_q[c][cmd.div_bit] <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			red_q   <= quo_q[0];
			green_q <= quo_q[1];
			blue_q  <= quo_q[2];
			last_q  <= is_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign red_out       = red_q;
	assign green_out     = green_q;
	assign blue_out      = blue_q;
	assign last_of_frame = last_q;

endmodule

FILE: src/bb3x3_ctrl.sv
// controller: accepts transactions and sequences taps, history write, division and output
module bb3x3_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   in_valid,
	input  logic [bb3x3_pkg::KIND_W-1:0] in_kind,
	output logic                   in_ready,
	input  bb3x3_pkg::status_t     status,
	output bb3x3_pkg::cmd_t        cmd
);

	localparam int STEP_W = bb3x3_pkg::STEP_W;
	localparam int QBIT_W = bb3x3_pkg::QBIT_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SETTLE = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_LAST   = 3'd3;
	localparam logic [2:0] ST_PREP   = 3'd4;
	localparam logic [2:0] ST_DIV    = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [2:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic [QBIT_W-1:0] bit_q;
	logic              pixel_q;
	logic              emit_q;
	logic              accept;
	logic              is_pix;

	assign in_ready = (state_q == ST_IDLE) && !cfg_we;
	assign accept   = in_valid && in_ready;
	// a pixel after the frame is complete counts as a flush
	assign is_pix   = (in_kind == bb3x3_pkg::KIND_PIXEL) && !status.frame_full;

	always_comb begin
		cmd           = '0;
		cmd.step      = step_q;
		cmd.pixel     = pixel_q;
		cmd.div_bit   = bit_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = accept;
				cmd.clear   = accept;
			end
			ST_READ:  cmd.rd        = 1'b1;
			ST_LAST:  cmd.wr        = pixel_q;
			ST_PREP:  cmd.div_start = 1'b1;
			ST_DIV:   cmd.div_step  = 1'b1;
			ST_OUT:   cmd.load_out  = status.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			bit_q   <= '0;
			pixel_q <= 1'b0;
			emit_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_we) begin
						state_q <= ST_SETTLE;
					end else if (accept) begin
						step_q <= '0;
						if (is_pix) begin
							pixel_q <= 1'b1;
							emit_q  <= status.history_primed;
							state_q <= status.history_primed ? ST_READ : ST_LAST;
						end else if (status.frame_full && status.emit_ok) begin
							pixel_q <= 1'b0;
							emit_q  <= 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_SETTLE: begin
					if (!cfg_we)
						state_q <= ST_IDLE;
				end
				ST_READ: begin
					if (step_q == bb3x3_pkg::LAST_TAP)
						state_q <= ST_LAST;
					else
						step_q <= step_q + STEP_W'(1);
				end
				ST_LAST: begin
					state_q <= emit_q ? ST_PREP : ST_IDLE;
				end
				ST_PREP: begin
					bit_q   <= QBIT_W'(bb3x3_pkg::CHAN_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (bit_q == '0)
						state_q <= ST_OUT;
					else
						bit_q <= bit_q - QBIT_W'(1);
				end
				ST_OUT: begin
					if (status.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: src/box_blur_3x3_edge_averaged_top.sv
// top level of the 3x3 edge-averaged box blur
//
// channel   dir  payload                                       transaction
// pixels    in   kind, red_in, green_in, blue_in               valid & ready
// blurred   out  red_out, green_out, blue_out, last_of_frame   valid & ready
// cfg       in   cfg_index, cfg_data                           cfg_we
//
// a pixel that yields no output only writes the line history, an ignored flush is dropped in idle
// a transaction that yields an output runs these steps, plus any wait on blurred:
// nine taps read one per cycle through the single port of the line history,
// then an 8-step shared restoring divider for the three channel means
// reset clears control state and sets the frame size to 640 by 480; line history contents are not cleared
// a finished output waits in the output register while the next transaction is taken;
// pixels is held off while cfg_we is high and in the settle state after each register write
module box_blur_3x3_edge_averaged_top (
	input  logic                              clk,
	input  logic                              arst_n,
	bb3x3_pix_if.sink                         pixels,
	bb3x3_res_if.source                       blurred,
	input  logic                              cfg_we,
	input  logic [bb3x3_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bb3x3_pkg::CFG_DATA_W-1:0]  cfg_data
);

	bb3x3_pkg::cmd_t    cmd;
	bb3x3_pkg::status_t status;
	logic               in_ready;

	bb3x3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.in_valid (pixels.valid),
		.in_kind  (pixels.kind),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	assign pixels.ready = in_ready;

	bb3x3_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.red_in        (pixels.red_in),
		.green_in      (pixels.green_in),
		.blue_in       (pixels.blue_in),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (blurred.valid),
		.out_ready     (blurred.ready),
		.red_out       (blurred.red_out),
		.green_out     (blurred.green_out),
		.blue_out      (blurred.blue_out),
		.last_of_frame (blurred.last_of_frame)
	);

endmodule
